@@ hdl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, codes and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OperandWidthDefault = 32;
	localparam int FieldWidth = 32;
	localparam int ProdWidth = 64;
	localparam int ResDenWidth = 63;

	typedef enum logic [2:0] {
		CMD_REDUCE = 3'd0,
		CMD_ADD    = 3'd1,
		CMD_SUB    = 3'd2,
		CMD_MUL    = 3'd3,
		CMD_DIV    = 3'd4,
		CMD_CMP    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMP_LESS    = 2'd0,
		CMP_EQUAL   = 2'd1,
		CMP_GREATER = 2'd2
	} cmp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_COMBINE,
		S_GCD_INIT,
		S_GCD,
		S_GCD_FIX,
		S_DIV_INIT,
		S_DIV,
		S_FINISH,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic combine;
		logic gcd_init;
		logic gcd_step;
		logic gcd_fix;
		logic div_init;
		logic div_step;
		logic finish;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic early;     // result settled at load, no arithmetic needed
		logic is_cmp;
		logic gcd_done;
		logic div_done;
	} stat_t;

endpackage

@@ hdl/rau_datapath.sv @@
// ----------------------------------------------------------------------------
// rau_datapath
// Operand decode, products, signed combine, binary GCD and restoring divides.
// ----------------------------------------------------------------------------
module rau_datapath #(
	parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rau_pkg::ctrl_t                       ctrl,
	output rau_pkg::stat_t                       stat,
	input  logic [2:0]                           cmd,
	input  logic [rau_pkg::FieldWidth-1:0]       left_num,
	input  logic [rau_pkg::FieldWidth-1:0]       left_den,
	input  logic [rau_pkg::FieldWidth-1:0]       right_num,
	input  logic [rau_pkg::FieldWidth-1:0]       right_den,
	output logic [rau_pkg::ProdWidth-1:0]        res_num,
	output logic [rau_pkg::ResDenWidth-1:0]      res_den,
	output logic [1:0]                           cmp_result,
	output logic [1:0]                           status
);
	import rau_pkg::*;

	localparam int MW = OPERAND_WIDTH;        // magnitude width incl. 2^(W-1)
	localparam int PW = 2 * OPERAND_WIDTH;    // product width
	localparam int SW = PW + 1;               // sum width
	localparam int CW = $clog2(SW + 1);

	logic [MW-1:0] ln_q, ld_q, rn_q, rd_q;
	logic lnn_q, ldn_q, rnn_q, rdn_q;
	logic [2:0] cmd_q;
	logic [PW-1:0] p1_q, p2_q, p3_q;
	logic [SW-1:0] n_q, d_q;        // working fraction magnitude
	logic neg_q;
	logic [SW-1:0] a_q, b_q;        // gcd operands
	logic [CW-1:0] sh_q;
	logic [SW-1:0] g_q;
	logic [SW-1:0] qn_q, rn_rem_q, qd_q, rd_rem_q;
	logic [CW-1:0] cnt_q;
	logic early_q;
	logic [1:0] cmp_q, st_q;

	function automatic logic [MW:0] mag_of(input logic [FieldWidth-1:0] raw);
		logic [MW-1:0] m;
		m = raw[MW-1:0];
		if (m[MW-1]) return {1'b1, MW'(-m)};
		return {1'b0, m};
	endfunction

	logic [MW:0] lnx, ldx, rnx, rdx;
	assign lnx = mag_of(left_num);
	assign ldx = mag_of(left_den);
	assign rnx = mag_of(right_num);
	assign rdx = mag_of(right_den);

	// one multiplier, shared by the S_MUL1 and S_MUL2 states
	logic [MW-1:0] ma, mb;
	logic [PW-1:0] mprod;
	always_comb begin
		ma = ln_q;
		mb = rd_q;
		case (cmd_q)
			CMD_MUL: begin
				if (ctrl.mul1) begin ma = ln_q; mb = rn_q; end
				else begin ma = ld_q; mb = rd_q; end
			end
			CMD_DIV: begin
				if (ctrl.mul1) begin ma = ln_q; mb = rd_q; end
				else begin ma = ld_q; mb = rn_q; end
			end
			default: begin
				if (ctrl.mul1) begin ma = ln_q; mb = rd_q; end
				else begin ma = rn_q; mb = ld_q; end
			end
		endcase
	end
	assign mprod = PW'(ma) * PW'(mb);
	// ld*rd for add/sub comes from a second multiplier in the S_MUL2 state
	logic [PW-1:0] mprod3;
	assign mprod3 = PW'(ld_q) * PW'(rd_q);

	// gcd: binary, one step a cycle
	logic gcd_fin;
	assign gcd_fin = (b_q == '0) || (a_q == '0);

	// divide: restoring, one bit a cycle, n and d by g together
	logic [SW:0] trn, trd;
	assign trn = {rn_rem_q, qn_q[SW-1]} - {1'b0, g_q};
	assign trd = {rd_rem_q, qd_q[SW-1]} - {1'b0, g_q};

	assign stat.early = early_q;
	assign stat.is_cmp = (cmd_q == CMD_CMP);
	assign stat.gcd_done = gcd_fin;
	assign stat.div_done = (cnt_q == CW'(SW - 1));

	logic s1, s2;
	logic [SW-1:0] e1, e2;
	logic signed [SW:0] sl, sr;
	always_comb begin
		s1 = lnn_q ^ rdn_q;
		s2 = (rnn_q ^ ldn_q) ^ (cmd_q == CMD_SUB);
		e1 = SW'(p1_q);
		e2 = SW'(p2_q);
		// compare: each side takes the sign of its own fraction
		sl = (lnn_q ^ ldn_q) ? -$signed({1'b0, e1}) : $signed({1'b0, e1});
		sr = (rnn_q ^ rdn_q) ? -$signed({1'b0, e2}) : $signed({1'b0, e2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			early_q <= 1'b0;
			cmp_q <= CMP_LESS;
			st_q <= ST_OK;
			cnt_q <= '0;
		end else begin
			if (ctrl.load) begin
				cmd_q <= cmd;
				ln_q <= lnx[MW-1:0]; lnn_q <= lnx[MW];
				ld_q <= ldx[MW-1:0]; ldn_q <= ldx[MW];
				rn_q <= rnx[MW-1:0]; rnn_q <= rnx[MW];
				rd_q <= rdx[MW-1:0]; rdn_q <= rdx[MW];
				cmp_q <= CMP_LESS;
				st_q <= ST_OK;
				early_q <= 1'b0;
				if (cmd > CMD_CMP) early_q <= 1'b1;
				else if (ldx[MW-1:0] == '0 || (cmd != CMD_REDUCE && rdx[MW-1:0] == '0)) begin
					early_q <= 1'b1; st_q <= ST_ZERO_DEN;
				end else if (cmd == CMD_DIV && rnx[MW-1:0] == '0) begin
					early_q <= 1'b1; st_q <= ST_DIV_ZERO;
				end
			end
			if (ctrl.mul1) p1_q <= mprod;
			if (ctrl.mul2) begin
				p2_q <= mprod;
				p3_q <= mprod3;
			end
			if (ctrl.combine) begin
				case (cmd_q)
					CMD_REDUCE: begin
						n_q <= SW'(ln_q); d_q <= SW'(ld_q); neg_q <= lnn_q ^ ldn_q;
					end
					CMD_MUL, CMD_DIV: begin
						n_q <= SW'(p1_q); d_q <= SW'(p2_q);
						neg_q <= lnn_q ^ ldn_q ^ rnn_q ^ rdn_q;
					end
					CMD_CMP: begin
						if (sl < sr) cmp_q <= CMP_LESS;
						else if (sl == sr) cmp_q <= CMP_EQUAL;
						else cmp_q <= CMP_GREATER;
					end
					default: begin
						d_q <= SW'(p3_q);
						if (s1 == s2) begin
							n_q <= e1 + e2; neg_q <= s1 ^ ldn_q ^ rdn_q;
						end else if (e1 >= e2) begin
							n_q <= e1 - e2; neg_q <= s1 ^ ldn_q ^ rdn_q;
						end else begin
							n_q <= e2 - e1; neg_q <= s2 ^ ldn_q ^ rdn_q;
						end
					end
				endcase
			end
			if (ctrl.gcd_init) begin
				a_q <= n_q; b_q <= d_q; sh_q <= '0;
			end
			if (ctrl.gcd_step && !gcd_fin) begin
				if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1; b_q <= b_q >> 1; sh_q <= sh_q + 1'b1;
				end else if (!a_q[0]) a_q <= a_q >> 1;
				else if (!b_q[0]) b_q <= b_q >> 1;
				else if (a_q >= b_q) a_q <= (a_q - b_q) >> 1;
				else b_q <= (b_q - a_q) >> 1;
			end
			if (ctrl.gcd_fix) begin
				// restore the shared power of two; gcd of x and 0 is x
				g_q <= (a_q | b_q) << sh_q;
			end
			if (ctrl.div_init) begin
				qn_q <= n_q; qd_q <= d_q;
				rn_rem_q <= '0; rd_rem_q <= '0; cnt_q <= '0;
			end
			if (ctrl.div_step) begin
				cnt_q <= cnt_q + 1'b1;
				if (!trn[SW]) begin
					rn_rem_q <= trn[SW-1:0]; qn_q <= {qn_q[SW-2:0], 1'b1};
				end else begin
					rn_rem_q <= {rn_rem_q[SW-2:0], qn_q[SW-1]}; qn_q <= {qn_q[SW-2:0], 1'b0};
				end
				if (!trd[SW]) begin
					rd_rem_q <= trd[SW-1:0]; qd_q <= {qd_q[SW-2:0], 1'b1};
				end else begin
					rd_rem_q <= {rd_rem_q[SW-2:0], qd_q[SW-1]}; qd_q <= {qd_q[SW-2:0], 1'b0};
				end
			end
		end
	end

	// output formatting
	logic [SW-1:0] nm;
	always_comb begin
		nm = qn_q;
		res_num = '0;
		res_den = '0;
		cmp_result = cmp_q;
		status = st_q;
		if (early_q) begin
			cmp_result = CMP_LESS;
		end else if (cmd_q != CMD_CMP) begin
			res_num = (neg_q && nm != '0) ? -ProdWidth'(nm) : ProdWidth'(nm);
			res_den = ResDenWidth'(qd_q);
		end
	end

	ap_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.finish && !early_q) |-> qd_q != '0) else $error("zero reduced denominator");

endmodule

@@ hdl/rau_ctrl.sv @@
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer for the rational unit: products, gcd loop, divide loop, output.
// ----------------------------------------------------------------------------
module rau_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic           out_fire,
	input  rau_pkg::stat_t stat,
	output rau_pkg::ctrl_t ctrl,
	output logic           busy,
	output logic           res_valid
);
	import rau_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		ctrl.load = in_fire;
		busy = (state_q != S_IDLE);
		res_valid = (state_q == S_OUT);
		case (state_q)
			S_IDLE: if (in_fire) state_d = S_MUL1;
			S_MUL1: begin
				if (stat.early) state_d = S_OUT;
				else begin ctrl.mul1 = 1'b1; state_d = S_MUL2; end
			end
			S_MUL2: begin ctrl.mul2 = 1'b1; state_d = S_COMBINE; end
			S_COMBINE: begin
				ctrl.combine = 1'b1;
				state_d = stat.is_cmp ? S_OUT : S_GCD_INIT;
			end
			S_GCD_INIT: begin ctrl.gcd_init = 1'b1; state_d = S_GCD; end
			S_GCD: begin
				ctrl.gcd_step = 1'b1;
				if (stat.gcd_done) state_d = S_GCD_FIX;
			end
			S_GCD_FIX: begin ctrl.gcd_fix = 1'b1; state_d = S_DIV_INIT; end
			S_DIV_INIT: begin ctrl.div_init = 1'b1; state_d = S_DIV; end
			S_DIV: begin
				ctrl.div_step = 1'b1;
				if (stat.div_done) state_d = S_FINISH;
			end
			S_FINISH: begin ctrl.finish = 1'b1; state_d = S_OUT; end
			S_OUT: if (out_fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	ap_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == S_IDLE) else $error("item taken while busy");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_fire) |=> state_q == S_OUT) else $error("result dropped");
	ap_div_after_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_INIT) |-> $past(state_q) == S_GCD_FIX) else $error("divide skipped gcd");

endmodule

@@ hdl/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction reduce/add/sub/mul/div/compare with gcd reduction.
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata: cmd, left_num, left_den, right_num, right_den
// m_axis   out  tdata: res_num, res_den, cmp_result, status
//
// One item at a time. Early results (bad code, zero denominator, divide by
// zero) go from S_MUL1 straight to S_OUT; compares pass S_MUL1, S_MUL2 and
// S_COMBINE before S_OUT. Other items run both product states and the combine,
// then the binary gcd loop, the gcd fix and the bit-serial divide by the gcd;
// the gcd loop and the divider set how long such an item takes.
// The result waits in the datapath registers until m_axis_tready; the next
// item can be taken in the cycle after the result leaves.
// arst_n clears the sequencer; no clearing pass is needed.
module rational_arithmetic_unit #(
	parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cmd[2:0], left_num[34:3], left_den[66:35], right_num[98:67],
	// right_den[130:99], zero fill
	input  logic [135:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// res_num[63:0], res_den[126:64], cmp_result[128:127], status[130:129], zero fill
	output logic [135:0] m_axis_tdata
);
	import rau_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	logic busy, in_fire, out_fire;
	logic [ProdWidth-1:0] res_num;
	logic [ResDenWidth-1:0] res_den;
	logic [1:0] cmp_result, status;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.stat(stat), .ctrl(ctrl), .busy(busy), .res_valid(m_axis_tvalid)
	);

	rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.cmd(s_axis_tdata[2:0]),
		.left_num(s_axis_tdata[34:3]), .left_den(s_axis_tdata[66:35]),
		.right_num(s_axis_tdata[98:67]), .right_den(s_axis_tdata[130:99]),
		.res_num(res_num), .res_den(res_den), .cmp_result(cmp_result), .status(status)
	);

	assign m_axis_tdata = {5'd0, status, cmp_result, res_den, res_num};

endmodule
